// ----- sv/b64sc_pkg.sv -----
// Shared types, constants and character functions for the Base64 stream codec.
// No dependencies; every other file but b64sc_if.sv imports this package.
package b64sc_pkg;

  localparam logic [7:0] CH_PAD = 8'h3D;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  typedef struct packed {
    logic            valid;
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
    logic            last;
    logic            bad;
  } b64sc_result_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } b64sc_sextet_t;

  function automatic logic [7:0] b64sc_char(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26) begin
      c = 8'h41 + {2'b00, s};
    end else if (s < 6'd52) begin
      c = 8'h61 + {2'b00, s - 6'd26};
    end else if (s < 6'd62) begin
      c = 8'h30 + {2'b00, s - 6'd52};
    end else if (s == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  function automatic b64sc_sextet_t b64sc_sextet(input logic [7:0] c);
    b64sc_sextet_t r;
    r.valid = 1'b1;
    r.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.value = 6'd62;
    end else if (c == 8'h2F) begin
      r.value = 6'd63;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- sv/b64sc_if.sv -----
// Valid/ready channel interfaces for the input beats and the result beats.
// Standalone; no package dependency.
interface b64sc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;
  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64sc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       bad_input;
  modport source (output valid, output out_byte, output out_last, output bad_input,
                  input ready);
  modport sink (input valid, input out_byte, input out_last, input bad_input,
                output ready);
endinterface

// ----- sv/b64sc_group.sv -----
// Group assembler: holds the direction register and the partial group, and
// forms a full result group in a pending register. Uses b64sc_pkg, b64sc_in_if.
module b64sc_group
  import b64sc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write_en,
  input  logic          cfg_write_data,
  b64sc_in_if.sink      in_ch,
  input  logic          pend_take,
  output b64sc_result_t pend
);

  logic        direction;
  logic [23:0] group_bits;
  logic [1:0]  group_fill;
  logic [1:0]  pad_count;
  logic        group_error;

  logic [23:0] group_bits_next;
  logic [1:0]  pad_count_next;
  logic        group_error_next;
  logic [2:0]  n;
  logic        complete;
  logic        drop;
  logic        accept;
  logic [23:0] v;
  b64sc_sextet_t sx;
  b64sc_result_t res;

  assign in_ch.ready = !pend.valid || pend_take;
  assign accept = in_ch.valid && in_ch.ready;
  assign n = {1'b0, group_fill} + 3'd1;

  always_comb begin
    group_bits_next = group_bits;
    pad_count_next = pad_count;
    group_error_next = group_error;
    drop = 1'b0;
    complete = 1'b0;
    v = 24'd0;
    sx = b64sc_sextet(in_ch.data_byte);
    res.valid = 1'b1;
    res.bytes = '0;
    res.count = 3'd4;
    res.last = in_ch.end_of_message;
    res.bad = 1'b0;
    if (direction == DIR_ENCODE) begin
      group_bits_next = {group_bits[15:0], in_ch.data_byte};
      complete = (n == 3'd3) || in_ch.end_of_message;
      case (n)
        3'd1:    v = {group_bits_next[7:0], 16'd0};
        3'd2:    v = {group_bits_next[15:0], 8'd0};
        default: v = group_bits_next;
      endcase
      for (int i = 0; i < 4; i++) begin
        if (3'(i) > n) begin
          res.bytes[i] = CH_PAD;
        end else begin
          res.bytes[i] = b64sc_char(v[23 - 6 * i -: 6]);
        end
      end
    end else begin
      drop = (group_fill == 2'd0) &&
             (in_ch.data_byte == CH_CR || in_ch.data_byte == CH_LF);
      if (in_ch.data_byte == CH_PAD) begin
        group_bits_next = {group_bits[17:0], 6'd0};
        if (group_fill < 2'd2) begin
          group_error_next = 1'b1;
        end else begin
          pad_count_next = pad_count + 2'd1;
        end
      end else begin
        group_bits_next = {group_bits[17:0], sx.value};
        if (!sx.valid || pad_count != 2'd0) begin
          group_error_next = 1'b1;
        end
      end
      complete = (n == 3'd4) || in_ch.end_of_message;
      case (n)
        3'd1:    v = {group_bits_next[5:0], 18'd0};
        3'd2:    v = {group_bits_next[11:0], 12'd0};
        3'd3:    v = {group_bits_next[17:0], 6'd0};
        default: v = group_bits_next;
      endcase
      res.bytes[0] = v[23:16];
      res.bytes[1] = v[15:8];
      res.bytes[2] = v[7:0];
      res.count = (pad_count_next > 2'd2) ? 3'd1 : 3'd3 - {1'b0, pad_count_next};
      res.bad = group_error_next || (n < 3'd4);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
      group_bits <= '0;
      group_fill <= '0;
      pad_count <= '0;
      group_error <= 1'b0;
    end else if (cfg_write_en) begin
      direction <= cfg_write_data;
      group_bits <= '0;
      group_fill <= '0;
      pad_count <= '0;
      group_error <= 1'b0;
    end else if (accept && !drop) begin
      if (complete) begin
        group_bits <= '0;
        group_fill <= '0;
        pad_count <= '0;
        group_error <= 1'b0;
      end else begin
        group_bits <= group_bits_next;
        group_fill <= n[1:0];
        pad_count <= pad_count_next;
        group_error <= group_error_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend.valid <= 1'b0;
    end else if (accept && !drop && complete) begin
      pend <= res;
    end else if (pend_take) begin
      pend.valid <= 1'b0;
    end
  end

endmodule

// ----- sv/b64sc_drain.sv -----
// Result serializer: loads a pending group and sends its beats one per cycle
// while out_ch is ready. Uses b64sc_pkg and b64sc_out_if.
module b64sc_drain
  import b64sc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  b64sc_result_t pend,
  output logic          pend_take,
  b64sc_out_if.source   out_ch
);

  logic [3:0][7:0] bytes;
  logic [2:0]      remaining;
  logic [1:0]      idx;
  logic            last;
  logic            bad;
  logic            send;

  assign send = out_ch.valid && out_ch.ready;
  assign pend_take = (remaining == 3'd0) || (remaining == 3'd1 && out_ch.ready);

  assign out_ch.valid = remaining != 3'd0;
  assign out_ch.out_byte = bytes[idx];
  assign out_ch.out_last = last && (remaining == 3'd1);
  assign out_ch.bad_input = bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      idx <= '0;
    end else if (pend.valid && pend_take) begin
      remaining <= pend.count;
      idx <= '0;
    end else if (send) begin
      remaining <= remaining - 3'd1;
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pend.valid && pend_take) begin
      bytes <= pend.bytes;
      last <= pend.last;
      bad <= pend.bad;
    end
  end

endmodule

// ----- sv/base64_stream_codec_core.sv -----
// Base64 stream codec top level; uses b64sc_pkg, b64sc_if, b64sc_group, b64sc_drain.
// A completing beat's results go through the pending group register, then the drain.
// Input beats are taken every cycle while the pending group register is free; each
// group's results leave one per cycle while the output is ready, so encoding (four
// results per three inputs) is output-bound; decoding takes an input beat per cycle.
// Synchronous active-high reset sets direction to encode and empties all groups.
module base64_stream_codec_core
  import b64sc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic        cfg_write_data,
  b64sc_in_if.sink    in_ch,
  b64sc_out_if.source out_ch
);

  b64sc_result_t pend;
  logic          pend_take;

  b64sc_group u_group (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_ch          (in_ch),
    .pend_take      (pend_take),
    .pend           (pend)
  );

  b64sc_drain u_drain (
    .clk       (clk),
    .rst       (rst),
    .pend      (pend),
    .pend_take (pend_take),
    .out_ch    (out_ch)
  );

endmodule

// ----- test/base64_stream_codec_core_tb.sv -----
// Self-checking testbench for base64_stream_codec_core: a directed table, then random
// encode and decode messages with random idling on both channels.
// Uses b64sc_pkg, the b64sc_in_if / b64sc_out_if channels and the core design files.
`timescale 1ns / 100ps

module base64_stream_codec_core_tb;
  import b64sc_pkg::*;

  typedef enum logic {ROW_BEAT, ROW_DIR} row_kind_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       bad_input;
  } codec_beat_t;

  typedef struct packed {
    row_kind_t       kind;
    logic [7:0]      data;
    logic            eom;
    logic [2:0]      n_known;
    logic [3:0][7:0] want;
    logic            want_bad;
  } row_t;

  localparam logic [511:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic cfg_write_data;

  b64sc_in_if  in_ch ();
  b64sc_out_if out_ch ();

  base64_stream_codec_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_ch         (in_ch),
    .out_ch        (out_ch)
  );

  logic        dir_mode;
  logic [23:0] grp_bits;
  logic [1:0]  grp_fill;
  logic [1:0]  grp_pads;
  logic        grp_err;

  codec_beat_t expected_beats [$];
  int          fail_count = 0;
  int          items_sent = 0;
  int          send_quiet = 0;
  int          recv_quiet = 0;

  row_t directed_rows [27] = '{
    {ROW_BEAT, 8'h00,   1'b1, 3'd4, {8'h41, 8'h41, CH_PAD, CH_PAD}, 1'b0},
    {ROW_BEAT, 8'hFF,   1'b0, 3'd0, 32'h0, 1'b0},
    {ROW_BEAT, 8'hFF,   1'b1, 3'd4, {8'h2F, 8'h2F, 8'h38, CH_PAD}, 1'b0},
    {ROW_BEAT, 8'hFF,   1'b0, 3'd0, 32'h0, 1'b0},
    {ROW_BEAT, 8'h00,   1'b0, 3'd0, 32'h0, 1'b0},
    {ROW_BEAT, 8'h80,   1'b0, 3'd0, 32'h0, 1'b0},
    {ROW_DIR,  {7'd0, DIR_DECODE}, 1'b0, 3'd0, 32'h0, 1'b0},
    {ROW_BEAT, 8'h54,   1'b0, 3'd0, 32'h0, 1'b0},
    {ROW_BEAT, 8'h57,   1'b0, 3'd0, 32'h0, 1'b0},
    {ROW_BEAT, 8'h46,   1'b0, 3'd0, 32'h0, 1'b0},
    {ROW_BEAT, 8'h75,   1'b1, 3'd3, {8'h4D, 8'h61, 8'h6E, 8'h00}, 1'b0},
    {ROW_BEAT, CH_CR,   1'b0, 3'd0, 32'h0, 1'b0},
    {ROW_BEAT, CH_LF,   1'b1, 3'd0, 32'h0, 1'b0},
    {ROW_BEAT, 8'h51,   1'b0, 3'd0, 32'h0, 1'b0},
    {ROW_BEAT, 8'h51,   1'b0, 3'd0, 32'h0, 1'b0},
    {ROW_BEAT, CH_PAD,  1'b0, 3'd0, 32'h0, 1'b0},
    {ROW_BEAT, CH_PAD,  1'b1, 3'd1, {8'h41, 8'h00, 8'h00, 8'h00}, 1'b0},
    {ROW_BEAT, 8'h41,   1'b0, 3'd0, 32'h0, 1'b0},
    {ROW_BEAT, 8'h41,   1'b0, 3'd0, 32'h0, 1'b0},
    {ROW_BEAT, CH_PAD,  1'b0, 3'd0, 32'h0, 1'b0},
    {ROW_BEAT, 8'h41,   1'b0, 3'd0, 32'h0, 1'b0},
    {ROW_BEAT, CH_PAD,  1'b0, 3'd0, 32'h0, 1'b0},
    {ROW_BEAT, CH_LF,   1'b0, 3'd0, 32'h0, 1'b0},
    {ROW_BEAT, 8'hFF,   1'b0, 3'd0, 32'h0, 1'b0},
    {ROW_BEAT, 8'h00,   1'b0, 3'd3, {8'h00, 8'h00, 8'h00, 8'h00}, 1'b1},
    {ROW_BEAT, 8'h2F,   1'b0, 3'd0, 32'h0, 1'b0},
    {ROW_BEAT, 8'h2F,   1'b1, 3'd3, {8'hFF, 8'hF0, 8'h00, 8'h00}, 1'b1}
  };

  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    return B64_ALPHABET[8 * (63 - s) +: 8];
  endfunction

  function automatic int char_sextet(input logic [7:0] c);
    for (int k = 0; k < 64; k++) begin
      if (sextet_char(6'(k)) == c) return k;
    end
    return -1;
  endfunction

  function automatic int pick_gap(input int quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet > 0 || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic drop_group();
    grp_bits = '0;
    grp_fill = '0;
    grp_pads = '0;
    grp_err  = 1'b0;
  endtask

  task automatic predict_beat(input logic [7:0] b, input logic eom,
                              output codec_beat_t [3:0] res, output int cnt);
    int          n;
    int          s;
    logic [23:0] v;
    logic [5:0]  sx;
    logic [7:0]  ch;
    res = '0;
    cnt = 0;
    if (dir_mode == DIR_ENCODE) begin
      grp_bits = {grp_bits[15:0], b};
      n = grp_fill + 1;
      if (n < 3 && !eom) begin
        grp_fill = 2'(n);
      end else begin
        v = grp_bits << (8 * (3 - n));
        for (int i = 0; i < 4; i++) begin
          sx = v[18 - 6 * i +: 6];
          ch = (i > n) ? CH_PAD : sextet_char(sx);
          res[i] = {ch, (i == 3) ? eom : 1'b0, 1'b0};
        end
        cnt = 4;
        drop_group();
      end
    end else if (!(grp_fill == 0 && (b == CH_CR || b == CH_LF))) begin
      s = char_sextet(b);
      if (b == CH_PAD) begin
        sx = '0;
        if (grp_fill < 2) grp_err = 1'b1;
        else grp_pads = grp_pads + 2'd1;
      end else if (s < 0) begin
        sx = '0;
        grp_err = 1'b1;
      end else begin
        sx = 6'(s);
        if (grp_pads != 0) grp_err = 1'b1;
      end
      grp_bits = {grp_bits[17:0], sx};
      n = grp_fill + 1;
      if (n < 4 && !eom) begin
        grp_fill = 2'(n);
      end else begin
        if (n < 4) grp_err = 1'b1;
        v = grp_bits << (6 * (4 - n));
        cnt = 3 - ((grp_pads > 2) ? 2 : grp_pads);
        for (int i = 0; i < cnt; i++) begin
          res[i] = {v[16 - 8 * i +: 8], (i + 1 == cnt) ? eom : 1'b0, grp_err};
        end
        drop_group();
      end
    end
  endtask

  // Called right after a rising edge; returns at the edge that took the beat.
  task automatic send_item(input logic [7:0] b, input logic eom, input logic [2:0] n_known,
                           input logic [3:0][7:0] want, input logic want_bad);
    codec_beat_t [3:0] res;
    int                cnt;
    int                gap;
    logic              took;
    if (send_quiet > 0) send_quiet--;
    else if ($urandom_range(0, 49) == 0) send_quiet = $urandom_range(20, 60);
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= b;
    in_ch.end_of_message <= eom;
    do begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end while (!took);
    predict_beat(b, eom, res, cnt);
    if (n_known != 0) begin
      cnt = n_known;
      for (int k = 0; k < cnt; k++) begin
        res[k] = {want[3 - k], eom && (k == cnt - 1), want_bad};
      end
    end
    for (int k = 0; k < cnt; k++) expected_beats.push_back(res[k]);
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
  endtask

  task automatic set_direction(input logic d);
    hold_until_drained();
    repeat (12) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= d;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    dir_mode = d;
    drop_group();
  endtask

  task automatic send_byte_message();
    int   len;
    logic closes;
    len    = $urandom_range(1, 10);
    closes = ($urandom_range(0, 7) != 0);
    for (int j = 0; j < len; j++) begin
      send_item(8'($urandom_range(0, 255)), closes && j == len - 1, 3'd0, 32'h0, 1'b0);
      items_sent++;
    end
  endtask

  task automatic send_text_message();
    int         ngroups;
    int         pads;
    int         nchars;
    logic       closes;
    logic       break_end;
    logic [7:0] ch;
    ngroups   = $urandom_range(1, 3);
    closes    = ($urandom_range(0, 7) != 0);
    break_end = closes && ($urandom_range(0, 9) == 0);
    for (int g = 0; g < ngroups; g++) begin
      pads   = 0;
      nchars = 4;
      if (g == ngroups - 1) begin
        case ($urandom_range(0, 5))
          0: pads = 1;
          1: pads = 2;
          default: pads = 0;
        endcase
        if (closes && !break_end && $urandom_range(0, 7) == 0) nchars = $urandom_range(1, 3);
      end
      for (int p = 0; p < nchars; p++) begin
        ch = (p >= 4 - pads) ? CH_PAD : sextet_char(6'($urandom_range(0, 63)));
        if ($urandom_range(0, 15) == 0) ch = 8'($urandom_range(0, 255));
        send_item(ch, closes && !break_end && g == ngroups - 1 && p == nchars - 1,
                  3'd0, 32'h0, 1'b0);
        items_sent++;
      end
      if (g < ngroups - 1 && $urandom_range(0, 4) == 0) begin
        send_item(($urandom_range(0, 1) != 0) ? CH_CR : CH_LF, 1'b0, 3'd0, 32'h0, 1'b0);
      end
    end
    if (break_end) begin
      send_item(($urandom_range(0, 1) != 0) ? CH_CR : CH_LF, 1'b1, 3'd0, 32'h0, 1'b0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int hold_off;
    int run;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (recv_quiet > 0) recv_quiet--;
      else if ($urandom_range(0, 49) == 0) recv_quiet = $urandom_range(20, 60);
      hold_off = pick_gap(recv_quiet);
      run      = $urandom_range(1, 8);
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat (run) @(posedge clk);
    end
  end

  // A result beat is taken at the rising edge that follows this falling edge.
  always @(negedge clk) begin
    codec_beat_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: out_byte %h out_last %b bad_input %b",
               out_ch.out_byte, out_ch.out_last, out_ch.bad_input);
        fail_count++;
      end else begin
        want = expected_beats.pop_front();
        if (out_ch.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, out_ch.out_byte);
          fail_count++;
        end
        if (out_ch.out_last !== want.out_last) begin
          $error("out_last: expected %b, got %b", want.out_last, out_ch.out_last);
          fail_count++;
        end
        if (out_ch.bad_input !== want.bad_input) begin
          $error("bad_input: expected %b, got %b", want.bad_input, out_ch.bad_input);
          fail_count++;
        end
      end
    end
  end

  initial begin
    row_t cur;
    int   goal;
    logic paused;
    rst                  <= 1'b1;
    cfg_write_en         <= 1'b0;
    cfg_write_data       <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.data_byte      <= 8'h00;
    in_ch.end_of_message <= 1'b0;
    dir_mode = DIR_ENCODE;
    drop_group();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      cur = directed_rows[r];
      if (cur.kind == ROW_DIR) begin
        set_direction(cur.data[0]);
      end else begin
        send_item(cur.data, cur.eom, cur.n_known, cur.want, cur.want_bad);
        if (cur.data != CH_CR && cur.data != CH_LF) items_sent++;
      end
    end

    for (int phase = 0; phase < 6; phase++) begin
      set_direction((phase % 2 == 0) ? DIR_ENCODE : DIR_DECODE);
      goal   = items_sent + 72;
      paused = 1'b0;
      while (items_sent < goal) begin
        if (!paused && items_sent >= goal - 36) begin
          hold_until_drained();
          paused = 1'b1;
        end
        if (dir_mode == DIR_ENCODE) send_byte_message();
        else send_text_message();
      end
    end

    hold_until_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/b64sc_pkg.sv
sv/b64sc_if.sv
sv/b64sc_group.sv
sv/b64sc_drain.sv
sv/base64_stream_codec_core.sv
test/base64_stream_codec_core_tb.sv
